// ===== rtl/fsmc_pkg.sv =====
// Package for the flash save-memory controller: item codes, opcodes, status patterns.
// Used by every module under rtl/.
package fsmc_pkg;
    localparam logic [1:0] FUNC_CMD  = 2'd0;
    localparam logic [1:0] FUNC_STAT = 2'd1;
    localparam logic [1:0] FUNC_BUF  = 2'd2;
    localparam logic [1:0] FUNC_READ = 2'd3;

    localparam logic [7:0] OP_ERASE_SETUP = 8'h4B;
    localparam logic [7:0] OP_ERASE_BLOCK = 8'h78;
    localparam logic [7:0] OP_WRITE_INIT  = 8'hB4;
    localparam logic [7:0] OP_SET_PAGE    = 8'hA5;
    localparam logic [7:0] OP_EXECUTE     = 8'hD2;
    localparam logic [7:0] OP_STATUS_MODE = 8'hE1;
    localparam logic [7:0] OP_READ_MODE   = 8'hF0;

    localparam logic [1:0] MODE_NOOP   = 2'd0;
    localparam logic [1:0] MODE_ERASE  = 2'd1;
    localparam logic [1:0] MODE_WRITE  = 2'd2;
    localparam logic [1:0] MODE_STATUS = 2'd3;

    localparam logic [31:0] ST_ERASE  = 32'h11118008;
    localparam logic [31:0] ST_WRITE  = 32'h11118004;
    localparam logic [31:0] ST_STATUS = 32'h11118001;
    localparam logic [31:0] ST_ID     = 32'h00C20000;
    localparam logic [31:0] ST_READ1  = 32'hF0000000;

    localparam logic [31:0] BUF_ADDR_A = 32'hA8000000;
    localparam logic [31:0] BUF_ADDR_B = 32'h88000000;
    localparam logic [15:0] PAGE_LEN   = 16'd128;

    // Input item as carried on the stream
    typedef struct packed {
        logic [7:0]  byte_value;
        logic [6:0]  byte_pos;
        logic [15:0] transfer_length;
        logic [31:0] flash_address;
        logic        status_select;
        logic [31:0] command_word;
        logic [1:0]  func;
    } item_t;
endpackage

// ===== rtl/fsmc_front.sv =====
// Front end: accepts beats and holds them in a short queue for the back end.
// Depends on fsmc_pkg.
module fsmc_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fsmc_pkg::item_t  s_item,
    output logic             q_valid,
    input  logic             q_ready,
    output fsmc_pkg::item_t  q_item
);
    import fsmc_pkg::*;

    item_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_item  = mem_reg[rp_reg];

    // two-entry queue
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= s_item;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count overflow");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !s_ready) else $error("ready while full");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !q_valid) else $error("valid while empty");
endmodule

// ===== rtl/fsmc_back.sv =====
// Back end: executes items against mode, status, page buffer and flash array.
// Depends on fsmc_pkg.
module fsmc_back #(
    parameter int ARRAY_BYTES = 131072
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  fsmc_pkg::item_t  q_item,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [31:0]      m_status_word,
    output logic [7:0]       m_read_byte,
    output logic             m_read_done
);
    import fsmc_pkg::*;

    localparam int AW = $clog2(ARRAY_BYTES);
    localparam int PAGES = ARRAY_BYTES / 128;
    localparam int PW = AW - 7;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_EXEC, S_OUT} state_t;

    state_t       state_reg;
    logic [7:0]   flash_mem [ARRAY_BYTES];
    logic [7:0]   pbuf_mem  [128];
    logic [1:0]   mode_reg;
    logic [PW-1:0] page_reg;
    logic [31:0]  st0_reg, st1_reg;
    logic [AW:0]  clr_reg;
    logic [7:0]   idx_reg;
    logic [AW-1:0] raddr_reg;
    logic [7:0]   rdata_reg, pdata_reg;
    logic         ex_wr_reg, ex_erase_reg;
    logic [6:0]   ex_i_reg;
    logic         isst_reg;
    logic [31:0]  osw_reg;
    logic [7:0]   orb_reg;
    logic         odone_reg;

    logic [7:0]   opc;
    logic [PW-1:0] cmd_page;
    logic [20:0]  start_w, sum_w;
    logic         rd_ok, buf_ok;
    logic [7:0]   st_byte;
    logic [63:0]  st_all;

    assign q_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_status_word = osw_reg;
    assign m_read_byte   = orb_reg;
    assign m_read_done   = odone_reg;

    assign opc      = q_item.command_word[31:24];
    assign cmd_page = PW'(q_item.command_word[15:0] % 16'(PAGES));
    // start is twice the address masked to bits [16:0]; 21 bits wide, enough for arrays below 2^21 bytes
    assign start_w  = {3'b000, q_item.flash_address[16:0], 1'b0};
    assign sum_w    = start_w + 21'(q_item.byte_pos);
    assign rd_ok    = (start_w < 21'(ARRAY_BYTES)) && (sum_w < 21'(ARRAY_BYTES));
    assign buf_ok   = (q_item.flash_address == BUF_ADDR_A ||
                       q_item.flash_address == BUF_ADDR_B) && q_item.transfer_length == PAGE_LEN;
    assign st_all   = {st1_reg, st0_reg};
    assign st_byte  = (q_item.byte_pos < 7'd8) ? st_all[q_item.byte_pos[2:0]*8 +: 8] : 8'd0;

    // flash array port: clear sweep, page program, and registered read
    always_ff @(posedge aclk) begin
        if (state_reg == S_CLEAR) begin
            flash_mem[clr_reg[AW-1:0]] <= 8'hFF;
        end else if (ex_wr_reg) begin
            flash_mem[{page_reg, ex_i_reg}] <= ex_erase_reg ? 8'hFF : pdata_reg;
        end
        rdata_reg <= flash_mem[raddr_reg];
    end

    // page buffer port
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && q_valid && q_item.func == FUNC_BUF && buf_ok) begin
            pbuf_mem[q_item.byte_pos] <= q_item.byte_value;
        end
        pdata_reg <= pbuf_mem[idx_reg[6:0]];
    end

    // control sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            mode_reg  <= MODE_NOOP;
            page_reg  <= '0;
            st0_reg   <= '0;
            st1_reg   <= '0;
            ex_wr_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            ex_wr_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(ARRAY_BYTES - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: if (q_valid) begin
                    osw_reg   <= '0;
                    orb_reg   <= '0;
                    odone_reg <= 1'b0;
                    isst_reg  <= 1'b0;
                    state_reg <= S_OUT;
                    unique case (q_item.func)
                        FUNC_CMD: begin
                            unique case (opc)
                                OP_ERASE_SETUP: begin
                                    mode_reg <= MODE_ERASE; page_reg <= cmd_page;
                                end
                                OP_ERASE_BLOCK: begin st0_reg <= ST_ERASE; st1_reg <= ST_ID; end
                                OP_WRITE_INIT: mode_reg <= MODE_WRITE;
                                OP_SET_PAGE: begin
                                    page_reg <= cmd_page; st0_reg <= ST_WRITE; st1_reg <= ST_ID;
                                end
                                OP_EXECUTE: if (mode_reg == MODE_ERASE || mode_reg == MODE_WRITE) begin
                                    ex_erase_reg <= (mode_reg == MODE_ERASE);
                                    idx_reg   <= '0;
                                    state_reg <= S_EXEC;
                                end
                                OP_STATUS_MODE: begin
                                    mode_reg <= MODE_STATUS; st0_reg <= ST_STATUS; st1_reg <= ST_ID;
                                end
                                OP_READ_MODE: begin
                                    mode_reg <= MODE_NOOP; page_reg <= '0;
                                    st0_reg <= ST_WRITE; st1_reg <= ST_READ1;
                                end
                                default: ;
                            endcase
                        end
                        FUNC_STAT: osw_reg <= q_item.status_select ? st1_reg : st0_reg;
                        FUNC_BUF: ;
                        FUNC_READ: if (16'(q_item.byte_pos) < q_item.transfer_length) begin
                            if (mode_reg == MODE_STATUS) begin
                                orb_reg <= st_byte; odone_reg <= 1'b1;
                            end else if (rd_ok) begin
                                raddr_reg <= sum_w[AW-1:0];
                                odone_reg <= 1'b1;
                                state_reg <= S_RD;
                            end
                        end
                        default: ;
                    endcase
                end
                // the array data is first registered into rdata_reg, then captured into orb_reg
                S_RD: begin
                    if (isst_reg) begin
                        orb_reg   <= rdata_reg;
                        isst_reg  <= 1'b0;
                        state_reg <= S_OUT;
                    end else begin
                        isst_reg <= 1'b1;
                    end
                end
                S_EXEC: begin
                    // buffer read is registered into pdata_reg, ahead of the array write that uses it
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg != 8'd128) begin
                        ex_wr_reg <= 1'b1;
                        ex_i_reg  <= idx_reg[6:0];
                    end
                    if (idx_reg == 8'd128) state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !q_ready) else $error("accepting while result pending");
    a_exec_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |-> idx_reg <= 8'd128) else $error("execute overrun");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !q_ready) else $error("accept during clear");
endmodule

// ===== rtl/flash_save_memory_controller_top.sv =====
// Flash save-memory controller top level. Depends on fsmc_pkg, fsmc_front, fsmc_back.
// Timing: beats are registered in the front queue; the result is valid in the cycle after
// the back end takes the item, but array reads first pass through S_RD (rdata_reg, then
// orb_reg) and executes walk the page in S_EXEC. No new item is taken until S_OUT is left.
// Reset: synchronous active-low; a clearing pass over all ARRAY_BYTES addresses then fills
// the array with 0xFF, while the front queue can still take up to two beats.
module flash_save_memory_controller_top #(
    parameter int ARRAY_BYTES = 131072
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func[1:0], command_word[33:2], status_select[34], flash_address[66:35],
    // transfer_length[82:67], byte_pos[89:83], byte_value[97:90], zero[103:98]
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status_word[31:0], read_byte[39:32], read_done[40], zero[47:41]
    output logic [47:0]  m_tdata
);
    import fsmc_pkg::*;

    item_t       q_item;
    logic        q_valid, q_ready;
    logic [31:0] sw;
    logic [7:0]  rb;
    logic        rd;

    fsmc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_tvalid), .s_ready(s_tready), .s_item(item_t'(s_tdata[97:0])),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    fsmc_back #(.ARRAY_BYTES(ARRAY_BYTES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_status_word(sw), .m_read_byte(rb), .m_read_done(rd)
    );

    assign m_tdata = {7'd0, rd, rb, sw};
endmodule
